// ----- hw/rtl/uart_pkg.sv -----
// Package for the 8N1 serial transceiver core.
// Holds the field widths, reset values, register indexes and receiver phase type.
// No dependencies.
package uart_pkg;

    localparam int BYTE_W            = 8;
    localparam int DATA_BITS_DEFAULT = 8;

    localparam int CPB_W     = 16;
    localparam int TIMEOUT_W = 32;
    localparam int CFG_W     = 32;
    localparam int CFG_IDX_W = 1;

    localparam logic [CPB_W-1:0]     CYCLES_PER_BIT_RESET = 16'd6076;
    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET        = 32'hFFFF_FFFF;

    localparam logic [CFG_IDX_W-1:0] REG_CYCLES_PER_BIT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT        = 1'b1;

    // Beat payload widths, padded to whole bytes.
    localparam int IN_DATA_W  = 16;
    localparam int OUT_DATA_W = 16;

    typedef enum logic [1:0] {
        RX_IDLE   = 2'd0,
        RX_WAIT   = 2'd1,
        RX_CENTER = 2'd2,
        RX_DATA   = 2'd3
    } rx_phase_t;

endpackage

// ----- hw/rtl/uart_8n1_transceiver_core.sv -----
// 8N1 serial transmitter and receiver, one input beat per clock tick of the line.
// Depends on uart_pkg.
//
// Each input beat is one tick of the serial line: it carries the sampled receive
// level, a send request with its byte and a receive request, and produces exactly
// one output beat with the transmit level, busy flags and any received byte or
// start-bit timeout. The core takes one beat every clock cycle while s_tready is high;
// the result appears on the master side in the cycle after acceptance, held in an output register, and
// s_tready only drops when that register is full and m_tready is low. Frames are
// one start bit, DATA_BITS data bits LSB first and one stop bit, each lasting
// cycles_per_bit beats (0 acts as 1). The receiver samples each data bit at its
// center and does not check the stop bit. Configuration writes take effect at once.
module uart_8n1_transceiver_core
    import uart_pkg::*;
#(
    parameter int DATA_BITS = DATA_BITS_DEFAULT
)(
    input  logic                  clk,
    input  logic                  rst_n,
    // Input beat, tdata from bit 0: rx_level, send_request, send_byte[7:0],
    // receive_request, zero padding.
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,
    // Result beat, tdata from bit 0: tx_level, tx_busy, rx_valid, rx_byte[7:0],
    // rx_timeout, rx_busy, zero padding.
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_W-1:0]      cfg_data
);

    localparam int WIDE_W    = (DATA_BITS > BYTE_W) ? DATA_BITS : BYTE_W;
    localparam int TX_IDX_W  = $clog2(DATA_BITS + 2);
    localparam int SEL_W     = $clog2(DATA_BITS);
    localparam logic [TX_IDX_W-1:0] TX_STOP_IDX = TX_IDX_W'(DATA_BITS + 1);
    localparam logic [TX_IDX_W-1:0] TX_LAST_DATA = TX_IDX_W'(DATA_BITS);
    localparam logic [SEL_W-1:0]    RX_LAST_IDX = SEL_W'(DATA_BITS - 1);

    // Configuration registers.
    logic [CPB_W-1:0]     cycles_per_bit_reg;
    logic [TIMEOUT_W-1:0] timeout_cycles_reg;

    // Transmitter state.
    logic [DATA_BITS-1:0] tx_shift_reg, tx_shift_next;
    logic [TX_IDX_W-1:0]  tx_bit_index_reg, tx_bit_index_next;
    logic [CPB_W-1:0]     tx_cycle_count_reg, tx_cycle_count_next;
    logic                 tx_active_reg, tx_active_next;

    // Receiver state.
    rx_phase_t            rx_phase_reg, rx_phase_next;
    logic [DATA_BITS-1:0] rx_shift_reg, rx_shift_next;
    logic [SEL_W-1:0]     rx_bit_index_reg, rx_bit_index_next;
    logic [CPB_W-1:0]     rx_cycle_count_reg, rx_cycle_count_next;
    logic [TIMEOUT_W-1:0] rx_wait_count_reg, rx_wait_count_next;

    // Output register.
    logic                  out_valid_reg;
    logic [OUT_DATA_W-1:0] m_tdata_reg, m_tdata_next;

    // Input fields.
    logic              rx_level;
    logic              send_request;
    logic [BYTE_W-1:0] send_byte;
    logic              receive_request;
    logic              accept;

    assign rx_level        = s_tdata[0];
    assign send_request    = s_tdata[1];
    assign send_byte       = s_tdata[9:2];
    assign receive_request = s_tdata[10];

    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = m_tdata_reg;

    logic [CPB_W-1:0] cpb;
    logic [CPB_W-1:0] cpb_half;
    assign cpb      = (cycles_per_bit_reg == '0) ? CPB_W'(1) : cycles_per_bit_reg;
    assign cpb_half = cpb >> 1;

    // ---------------- Transmitter ----------------
    logic                 tx_start;
    logic                 tx_active_cur;
    logic [DATA_BITS-1:0] tx_shift_cur;
    logic [TX_IDX_W-1:0]  tx_idx_cur;
    logic [CPB_W-1:0]     tx_cnt_cur;
    logic [CPB_W:0]       tx_cnt_inc;
    logic [TX_IDX_W-1:0]  tx_data_pos;
    logic [WIDE_W-1:0]    send_wide;
    logic                 tx_level;
    logic                 tx_busy;

    assign send_wide     = WIDE_W'(send_byte);
    assign tx_start      = !tx_active_reg && send_request;
    assign tx_active_cur = tx_active_reg || send_request;
    assign tx_shift_cur  = tx_start ? send_wide[DATA_BITS-1:0] : tx_shift_reg;
    assign tx_idx_cur    = tx_start ? '0 : tx_bit_index_reg;
    assign tx_cnt_cur    = tx_start ? '0 : tx_cycle_count_reg;
    assign tx_cnt_inc    = {1'b0, tx_cnt_cur} + (CPB_W+1)'(1);
    assign tx_data_pos   = tx_idx_cur - TX_IDX_W'(1);

    always_comb
    begin
        tx_shift_next       = tx_shift_cur;
        tx_bit_index_next   = tx_idx_cur;
        tx_cycle_count_next = tx_cnt_cur;
        tx_active_next      = tx_active_cur;
        tx_level            = 1'b1;
        tx_busy             = 1'b0;
        if (tx_active_cur)
        begin
            tx_busy = 1'b1;
            if (tx_idx_cur == '0)
                tx_level = 1'b0;
            else if (tx_idx_cur <= TX_LAST_DATA)
                tx_level = tx_shift_cur[tx_data_pos[SEL_W-1:0]];
            else
                tx_level = 1'b1;

            if (tx_cnt_inc >= {1'b0, cpb})
            begin
                tx_cycle_count_next = '0;
                if (tx_idx_cur == TX_STOP_IDX)
                begin
                    tx_active_next    = 1'b0;
                    tx_bit_index_next = '0;
                end
                else
                begin
                    tx_bit_index_next = tx_idx_cur + TX_IDX_W'(1);
                end
            end
            else
            begin
                tx_cycle_count_next = tx_cnt_inc[CPB_W-1:0];
            end
        end
    end

    // ---------------- Receiver ----------------
    rx_phase_t            rx_phase_cur;
    logic [TIMEOUT_W-1:0] rx_wait_cur;
    logic [CPB_W:0]       rx_cnt_inc;
    logic                 rx_center_hit;
    logic                 rx_bit_hit;
    logic                 rx_wait_expired;
    logic [DATA_BITS-1:0] rx_shift_sampled;
    logic [WIDE_W-1:0]    rx_wide;
    logic                 rx_valid;
    logic [BYTE_W-1:0]    rx_byte;
    logic                 rx_timeout;
    logic                 rx_busy;

    assign rx_phase_cur    = (rx_phase_reg == RX_IDLE && receive_request) ? RX_WAIT
                                                                          : rx_phase_reg;
    assign rx_wait_cur     = (rx_phase_reg == RX_IDLE) ? '0 : rx_wait_count_reg;
    assign rx_cnt_inc      = {1'b0, rx_cycle_count_reg} + (CPB_W+1)'(1);
    assign rx_center_hit   = rx_cnt_inc >= {1'b0, cpb_half};
    assign rx_bit_hit      = rx_cnt_inc >= {1'b0, cpb};
    assign rx_wait_expired = rx_wait_cur >= timeout_cycles_reg;

    always_comb
    begin
        rx_shift_sampled                   = rx_shift_reg;
        rx_shift_sampled[rx_bit_index_reg] = rx_shift_reg[rx_bit_index_reg] | rx_level;
    end

    // Next-state logic.
    always_comb
    begin
        rx_phase_next       = rx_phase_cur;
        rx_shift_next       = rx_shift_reg;
        rx_bit_index_next   = rx_bit_index_reg;
        rx_cycle_count_next = rx_cycle_count_reg;
        rx_wait_count_next  = rx_wait_cur;
        case (rx_phase_cur)
            RX_WAIT:
            begin
                if (!rx_level)
                begin
                    rx_shift_next       = '0;
                    rx_bit_index_next   = '0;
                    rx_cycle_count_next = '0;
                    rx_phase_next       = (cpb_half == '0) ? RX_DATA : RX_CENTER;
                end
                else if (rx_wait_expired)
                begin
                    rx_phase_next = RX_IDLE;
                end
                else
                begin
                    rx_wait_count_next = rx_wait_cur + TIMEOUT_W'(1);
                end
            end
            RX_CENTER:
            begin
                if (rx_center_hit)
                begin
                    rx_cycle_count_next = '0;
                    rx_phase_next       = RX_DATA;
                end
                else
                begin
                    rx_cycle_count_next = rx_cnt_inc[CPB_W-1:0];
                end
            end
            RX_DATA:
            begin
                if (rx_bit_hit)
                begin
                    rx_cycle_count_next = '0;
                    rx_shift_next       = rx_shift_sampled;
                    if (rx_bit_index_reg == RX_LAST_IDX)
                    begin
                        rx_phase_next     = RX_IDLE;
                        rx_bit_index_next = '0;
                    end
                    else
                    begin
                        rx_bit_index_next = rx_bit_index_reg + SEL_W'(1);
                    end
                end
                else
                begin
                    rx_cycle_count_next = rx_cnt_inc[CPB_W-1:0];
                end
            end
            default:
            begin
                rx_phase_next = RX_IDLE;
            end
        endcase
    end

    assign rx_wide = WIDE_W'(rx_shift_sampled);

    // Output logic.
    always_comb
    begin
        rx_busy    = (rx_phase_cur != RX_IDLE);
        rx_timeout = 1'b0;
        rx_valid   = 1'b0;
        rx_byte    = '0;
        case (rx_phase_cur)
            RX_WAIT:
            begin
                rx_timeout = rx_level && rx_wait_expired;
            end
            RX_DATA:
            begin
                if (rx_bit_hit && rx_bit_index_reg == RX_LAST_IDX)
                begin
                    rx_valid = 1'b1;
                    rx_byte  = rx_wide[BYTE_W-1:0];
                end
            end
            default:
            begin
                rx_timeout = 1'b0;
            end
        endcase
    end

    assign m_tdata_next = OUT_DATA_W'({rx_busy, rx_timeout, rx_byte,
                                       rx_valid, tx_busy, tx_level});

    // ---------------- Registers ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cycles_per_bit_reg <= CYCLES_PER_BIT_RESET;
            timeout_cycles_reg <= TIMEOUT_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_CYCLES_PER_BIT: cycles_per_bit_reg <= cfg_data[CPB_W-1:0];
                REG_TIMEOUT:        timeout_cycles_reg <= cfg_data[TIMEOUT_W-1:0];
                default:            cycles_per_bit_reg <= cycles_per_bit_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tx_shift_reg       <= '0;
            tx_bit_index_reg   <= '0;
            tx_cycle_count_reg <= '0;
            tx_active_reg      <= 1'b0;
            rx_phase_reg       <= RX_IDLE;
            rx_shift_reg       <= '0;
            rx_bit_index_reg   <= '0;
            rx_cycle_count_reg <= '0;
            rx_wait_count_reg  <= '0;
        end
        else if (accept)
        begin
            tx_shift_reg       <= tx_shift_next;
            tx_bit_index_reg   <= tx_bit_index_next;
            tx_cycle_count_reg <= tx_cycle_count_next;
            tx_active_reg      <= tx_active_next;
            rx_phase_reg       <= rx_phase_next;
            rx_shift_reg       <= rx_shift_next;
            rx_bit_index_reg   <= rx_bit_index_next;
            rx_cycle_count_reg <= rx_cycle_count_next;
            rx_wait_count_reg  <= rx_wait_count_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (accept)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            m_tdata_reg <= m_tdata_next;
    end

endmodule
